// ----- rtl/planar_video_scaler_top_macros.svh -----
// Assertion macros shared by the scaler RTL.
// Each expands to a labelled concurrent assertion on clock, disabled in reset.
`ifndef PLANAR_VIDEO_SCALER_TOP_MACROS_SVH
`define PLANAR_VIDEO_SCALER_TOP_MACROS_SVH

// cons must hold in the same cycle as cond
`define PVS_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after cond
`define PVS_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pvs_pkg.sv -----
package pvs_pkg;

   localparam int WORD_W           = 16;
   localparam int WORDS_PER_LINE   = 64;
   localparam int COL_W            = $clog2(WORDS_PER_LINE);
   localparam int LINE_W           = 8;
   localparam int SOURCE_LINES_DEF = 256;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int MODE_W           = 3;
   localparam int COLOR_W          = 24;
   localparam int POS_W            = 10;
   localparam int CSR_IDX_W        = 3;
   localparam int RSP_TDATA_W      = 48;
   localparam int RSP_PAD_W        = RSP_TDATA_W - 2 * POS_W - COLOR_W;

   typedef logic [MODE_W-1:0]     mode_type;
   typedef logic [COLOR_W-1:0]    color_type;
   typedef logic [3:0][COLOR_W-1:0] palette_type;
   typedef logic [CSR_IDX_W-1:0]  csr_index_type;

   localparam mode_type MODE_NATIVE  = 3'd0;
   localparam mode_type MODE_SHIFTED = 3'd1;
   localparam mode_type MODE_SCALE32 = 3'd2;
   localparam mode_type MODE_SCALE74 = 3'd3;
   localparam mode_type MODE_DOUBLE  = 3'd4;

   localparam csr_index_type CSR_MODE      = 3'd0;
   localparam csr_index_type CSR_PAL_BLACK = 3'd1;
   localparam csr_index_type CSR_PAL_LIGHT = 3'd2;
   localparam csr_index_type CSR_PAL_DARK  = 3'd3;
   localparam csr_index_type CSR_PAL_WHITE = 3'd4;

   localparam color_type PAL_BLACK_RST = 24'h000000;
   localparam color_type PAL_LIGHT_RST = 24'hB0B0B0;
   localparam color_type PAL_DARK_RST  = 24'h404040;
   localparam color_type PAL_WHITE_RST = 24'hFFFFFF;

   localparam color_type AVG_MASK = 24'hFEFEFF;

   localparam logic [POS_W-1:0] ROW_SHIFT_NATIVE = 10'd28;
   localparam logic [POS_W-1:0] ROW_TOP_SCALE32  = 10'd42;
   localparam logic [POS_W-1:0] ROW_TOP_DOUBLED  = 10'd56;

   // one queued word with everything the back end needs
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] stored;
      logic [COL_W-1:0]  x;
      logic [LINE_W-1:0] y;
      mode_type          mode;
   } entry_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

   // red and green lose their low bit before the add, blue is an exact floor average
   function automatic color_type avg_rgb(input color_type a, input color_type b);
      logic [COLOR_W:0] sum;
      sum = {1'b0, a & AVG_MASK} + {1'b0, b & AVG_MASK};
      return sum[COLOR_W:1];
   endfunction

   // pixel b is taken MSB first from both planes
   function automatic logic [1:0] pixel_index(input logic [WORD_W-1:0] w, input logic [2:0] b);
      return {w[{1'b1, ~b}], w[{1'b0, ~b}]};
   endfunction

endpackage

// ----- rtl/pvs_queue.sv -----
`include "planar_video_scaler_top_macros.svh"

module pvs_queue
   import pvs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full       = (count_ff == CNT_W'(DEPTH));
   assign status.head_valid = (count_ff != '0);
   assign head_entry        = slots_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `PVS_ASSERT_NOW(a_queue_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count exceeds depth")
   `PVS_ASSERT_NOW(a_queue_no_overflow, push, !status.full, "push into a full queue")

endmodule

// ----- rtl/pvs_front.sv -----
module pvs_front
   import pvs_pkg::*;
#(
   parameter int SOURCE_LINES = SOURCE_LINES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_word,
   input  logic              req_frame_start,
   input  mode_type          mode,
   input  queue_status_type  queue_status,
   output logic              push,
   output entry_type         push_entry
);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic [COL_W-1:0]  x_cur;
   logic [LINE_W-1:0] y_cur;
   logic              accept;

   logic [WORD_W-1:0] store_mem [WORDS_PER_LINE];
   logic [WORD_W-1:0] stored_ff;

   logic              held_ff, held_in;
   logic [WORD_W-1:0] word_ff;
   logic [COL_W-1:0]  x_ff;
   logic [LINE_W-1:0] y_ff;
   mode_type          mode_ff;
   logic              emits;
   logic              held_done;

   assign x_cur  = req_frame_start ? '0 : col_ff;
   assign y_cur  = req_frame_start ? '0 : line_ff;
   assign accept = req_tvalid && req_tready;

   // words that produce no pixels are dropped here and never queued
   always_comb begin
      unique case (mode_ff) inside
         MODE_NATIVE, MODE_SHIFTED, MODE_SCALE74, MODE_DOUBLE: emits = 1'b1;
         MODE_SCALE32: emits = y_ff[0];
         default:      emits = 1'b0;
      endcase
   end

   assign push       = held_ff && emits && !queue_status.full;
   assign held_done  = held_ff && (!emits || !queue_status.full);
   assign req_tready = !held_ff || held_done;

   assign push_entry.word   = word_ff;
   assign push_entry.stored = stored_ff;
   assign push_entry.x      = x_ff;
   assign push_entry.y      = y_ff;
   assign push_entry.mode   = mode_ff;

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      held_in = held_ff;
      if (held_done) begin
         held_in = 1'b0;
      end
      if (accept) begin
         held_in = 1'b1;
         if (x_cur == COL_W'(WORDS_PER_LINE - 1)) begin
            col_in  = '0;
            line_in = (y_cur == LINE_W'(SOURCE_LINES - 1)) ? '0 : y_cur + 1'b1;
         end else begin
            col_in  = x_cur + 1'b1;
            line_in = y_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         line_ff <= '0;
         held_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         line_ff <= line_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= req_word;
         x_ff    <= x_cur;
         y_ff    <= y_cur;
         mode_ff <= mode;
      end
   end

   // even lines are written, odd lines read: never both at one address in a cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         if (y_cur[0]) begin
            stored_ff <= store_mem[x_cur];
         end else begin
            store_mem[x_cur] <= req_word;
         end
      end
   end

endmodule

// ----- rtl/pvs_back.sv -----
`include "planar_video_scaler_top_macros.svh"

module pvs_back
   import pvs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  entry_type              head_entry,
   output logic                   pop,
   input  palette_type            palette,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam logic [1:0] SEL_FIRST  = 2'd0;
   localparam logic [1:0] SEL_BLEND  = 2'd1;
   localparam logic [1:0] SEL_SECOND = 2'd2;

   // a: pixel or group, r: row within the word's block, c: column within the group
   logic [2:0] a_ff, a_in;
   logic [1:0] r_ff, r_in;
   logic [2:0] c_ff, c_in;

   logic             load;
   logic             last;
   logic [2:0]       px0, px1;
   logic [1:0]       sel;
   color_type        upper_color, lower_color, color;
   logic [POS_W-1:0] row, col;
   logic [POS_W-1:0] k3;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff;
   logic [POS_W-1:0] rsp_row_ff, rsp_col_ff;
   color_type        rsp_color_ff;

   function automatic color_type line_color(input logic [WORD_W-1:0] w,
                                            input logic [2:0] p0,
                                            input logic [2:0] p1,
                                            input logic [1:0] s,
                                            input palette_type pal);
      color_type c0, c1, res;
      c0 = pal[pixel_index(w, p0)];
      c1 = pal[pixel_index(w, p1)];
      case (s)
         SEL_FIRST:  res = c0;
         SEL_BLEND:  res = avg_rgb(c0, c1);
         SEL_SECOND: res = c1;
         default:    res = c1;
      endcase
      return res;
   endfunction

   assign load = head_valid && (!rsp_valid_ff || rsp_tready);
   assign pop  = load && last;

   // three times the line pair number
   assign k3 = POS_W'({head_entry.y[LINE_W-1:1], 1'b0}) + POS_W'(head_entry.y[LINE_W-1:1]);

   always_comb begin
      px0  = a_ff;
      px1  = a_ff;
      sel  = SEL_FIRST;
      last = 1'b1;
      a_in = '0;
      r_in = '0;
      c_in = '0;
      row  = POS_W'(head_entry.y);
      col  = POS_W'({head_entry.x, a_ff});
      unique case (head_entry.mode) inside
         MODE_NATIVE, MODE_SHIFTED: begin
            last = (a_ff == 3'd7);
            a_in = a_ff + 1'b1;
            if (head_entry.mode == MODE_SHIFTED) begin
               row = POS_W'(head_entry.y) + ROW_SHIFT_NATIVE;
            end
         end
         MODE_SCALE32: begin
            px0  = {a_ff[1:0], 1'b0};
            px1  = {a_ff[1:0], 1'b1};
            sel  = c_ff[1:0];
            last = (a_ff == 3'd3) && (r_ff == 2'd2) && (c_ff == 3'd2);
            a_in = a_ff;
            r_in = r_ff;
            c_in = c_ff + 1'b1;
            if (c_ff == 3'd2) begin
               c_in = '0;
               if (r_ff == 2'd2) begin
                  r_in = '0;
                  a_in = a_ff + 1'b1;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end
            row = ROW_TOP_SCALE32 + k3 + POS_W'(r_ff);
            col = POS_W'({head_entry.x, 3'b000}) + POS_W'({head_entry.x, 2'b00})
                + POS_W'({a_ff, 1'b0}) + POS_W'(a_ff) + POS_W'(c_ff);
         end
         MODE_SCALE74: begin
            px0  = {a_ff[0], c_ff[2:1]};
            px1  = px0 + 1'b1;
            sel  = c_ff[0] ? SEL_BLEND : SEL_FIRST;
            last = (a_ff == 3'd1) && (c_ff == 3'd6) && (r_ff == 2'd1);
            a_in = a_ff;
            c_in = c_ff;
            r_in = r_ff + 1'b1;
            if (r_ff == 2'd1) begin
               r_in = '0;
               if (c_ff == 3'd6) begin
                  c_in = '0;
                  a_in = a_ff + 1'b1;
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
            row = ROW_TOP_DOUBLED + POS_W'({head_entry.y, 1'b0}) + POS_W'(r_ff);
            col = POS_W'({head_entry.x, 4'b0000}) - POS_W'({head_entry.x, 1'b0})
                + POS_W'({a_ff, 3'b000}) - POS_W'(a_ff) + POS_W'(c_ff);
         end
         MODE_DOUBLE: begin
            last = (a_ff == 3'd7) && (r_ff == 2'd1) && (c_ff == 3'd1);
            a_in = a_ff;
            r_in = r_ff;
            c_in = c_ff + 1'b1;
            if (c_ff == 3'd1) begin
               c_in = '0;
               if (r_ff == 2'd1) begin
                  r_in = '0;
                  a_in = a_ff + 1'b1;
               end else begin
                  r_in = r_ff + 1'b1;
               end
            end
            row = ROW_TOP_DOUBLED + POS_W'({head_entry.y, 1'b0}) + POS_W'(r_ff);
            col = {head_entry.x, a_ff, c_ff[0]};
         end
         default: begin
            last = 1'b1;
         end
      endcase
      if (last) begin
         a_in = '0;
         r_in = '0;
         c_in = '0;
      end
   end

   // scaled mode: row 0 from the stored line, row 2 from the current one, row 1 blends both
   always_comb begin
      upper_color = line_color(head_entry.stored, px0, px1, sel, palette);
      lower_color = line_color(head_entry.word, px0, px1, sel, palette);
      color       = lower_color;
      if (head_entry.mode == MODE_SCALE32) begin
         case (r_ff)
            2'd0:    color = upper_color;
            2'd1:    color = avg_rgb(upper_color, lower_color);
            default: color = lower_color;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            a_ff <= a_in;
            r_ff <= r_in;
            c_ff <= c_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_row_ff   <= row;
         rsp_col_ff   <= col;
         rsp_color_ff <= color;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_color_ff, rsp_col_ff, rsp_row_ff};

   `PVS_ASSERT_NEXT(a_back_last_clears, load && last, a_ff == '0 && r_ff == '0 && c_ff == '0, "sequencer not cleared after last pixel")
   `PVS_ASSERT_NOW(a_back_scale_range, head_valid && head_entry.mode == MODE_SCALE32, a_ff <= 3'd3 && r_ff <= 2'd2 && c_ff <= 3'd2, "scaled-mode sequencer out of range")

endmodule

// ----- rtl/planar_video_scaler_top.sv -----
// Two-plane video word to 24-bit pixel converter.
// req_*: one 16-bit word per transfer; req_tuser marks the first word of a frame and
//   clears the word column and source line counters before the word is placed.
// rsp_*: one pixel per transfer with its row and column; rsp_tlast marks the final
//   pixel that a word produces.
// csr_*: display mode (index 0) and four palette colours (indices 1 to 4), written
//   while the block is idle.
// Path: front holding register, then a queue slot, then the pixel output register.
// Throughput: one pixel per clock while words are queued and rsp_tready allows; a word gives
//   8 pixels in modes 0 and 1, 36 per odd-line word in mode 2, 28 in mode 3 and 32 in mode 4;
//   words that give no pixels (even lines in mode 2, unused modes) are dropped in the front.
//   The pixel sequencer in the back end steps through each word's pixels.
// A queue of QUEUE_DEPTH words lets the front keep accepting while pixels go out.
// Reset: counters clear, mode 0, palette to its defaults, queue and output empty.
//   The even-line store is undefined until an even line has been written.
// Stall: with rsp_tready low the output register holds, the sequencer waits, the
//   queue fills and then req_tready drops.
module planar_video_scaler_top
   import pvs_pkg::*;
#(
   parameter int SOURCE_LINES = SOURCE_LINES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [WORD_W-1:0]      req_tdata,   // video_word
   input  logic                   req_tuser,   // frame_start
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_row, out_col, pixel_color, zero pad
   output logic                   rsp_tlast,
   input  logic                   csr_wr_en,
   input  csr_index_type          csr_index,
   input  logic [COLOR_W-1:0]     csr_wdata
);

   mode_type         mode_ff;
   palette_type      palette_ff;
   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        head_entry;
   queue_status_type queue_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NATIVE;
         palette_ff[0] <= PAL_BLACK_RST;
         palette_ff[1] <= PAL_LIGHT_RST;
         palette_ff[2] <= PAL_DARK_RST;
         palette_ff[3] <= PAL_WHITE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODE:      mode_ff       <= csr_wdata[MODE_W-1:0];
            CSR_PAL_BLACK: palette_ff[0] <= csr_wdata;
            CSR_PAL_LIGHT: palette_ff[1] <= csr_wdata;
            CSR_PAL_DARK:  palette_ff[2] <= csr_wdata;
            CSR_PAL_WHITE: palette_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   pvs_front #(
      .SOURCE_LINES (SOURCE_LINES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_word        (req_tdata),
      .req_frame_start (req_tuser),
      .mode            (mode_ff),
      .queue_status    (queue_status),
      .push            (push),
      .push_entry      (push_entry)
   );

   pvs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   pvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_status.head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .palette    (palette_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import pvs_pkg::*;

   localparam int       WATCHDOG_LIMIT = 5000;
   localparam mode_type MODE_SILENT    = 3'd7;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      color_type        color;
      logic             last;
   } pixel_type;

   class raster_scoreboard;
      mode_type          mode;
      palette_type       palette;
      logic [COL_W-1:0]  column;
      logic [LINE_W-1:0] line;
      logic [WORD_W-1:0] line_store [WORDS_PER_LINE];
      pixel_type         pending_pixels [$];
      pixel_type         held;
      bit                holding;
      int                errors;

      function new();
         mode       = MODE_NATIVE;
         palette[0] = PAL_BLACK_RST;
         palette[1] = PAL_LIGHT_RST;
         palette[2] = PAL_DARK_RST;
         palette[3] = PAL_WHITE_RST;
         column     = '0;
         line       = '0;
         holding    = 1'b0;
         errors     = 0;
         foreach (line_store[i]) line_store[i] = '0;
      endfunction

      function void write_reg(csr_index_type idx, logic [COLOR_W-1:0] data);
         case (idx)
            CSR_MODE:      mode = data[MODE_W-1:0];
            CSR_PAL_BLACK: palette[0] = data;
            CSR_PAL_LIGHT: palette[1] = data;
            CSR_PAL_DARK:  palette[2] = data;
            CSR_PAL_WHITE: palette[3] = data;
            default: ;
         endcase
      endfunction

      // pixel b is read MSB first from both planes
      function color_type shade(logic [WORD_W-1:0] w, int b);
         logic [1:0] idx;
         idx = {w[15 - b], w[7 - b]};
         return palette[idx];
      endfunction

      // red and green drop their low bit before the add, blue is averaged exactly
      function color_type blend(color_type a, color_type b);
         logic [31:0] sum;
         sum = 32'(a & AVG_MASK) + 32'(b & AVG_MASK);
         return sum[COLOR_W:1];
      endfunction

      // hold the newest pixel back so the final one of a word can be flagged
      function void emit(int row, int col, color_type color);
         if (holding) pending_pixels.push_back(held);
         held    = '{POS_W'(row), POS_W'(col), color, 1'b0};
         holding = 1'b1;
      endfunction

      function void take_word(logic [WORD_W-1:0] w, logic frame_start);
         int          x;
         int          y;
         int          row;
         int          col;
         logic [WORD_W-1:0] s;
         color_type   sa, sb, wa, wb, sab, wab;
         color_type   c [4];
         color_type   seq [7];
         if (frame_start) begin
            column = '0;
            line   = '0;
         end
         x = int'(column);
         y = int'(line);
         case (mode)
            MODE_NATIVE, MODE_SHIFTED: begin
               row = y + ((mode == MODE_SHIFTED) ? int'(ROW_SHIFT_NATIVE) : 0);
               for (int b = 0; b < 8; b++) emit(row, 8 * x + b, shade(w, b));
            end
            MODE_SCALE32: begin
               if (line[0]) begin
                  s   = line_store[column];
                  row = int'(ROW_TOP_SCALE32) + 3 * (y >> 1);
                  for (int p = 0; p < 4; p++) begin
                     sa  = shade(s, 2 * p);
                     sb  = shade(s, 2 * p + 1);
                     wa  = shade(w, 2 * p);
                     wb  = shade(w, 2 * p + 1);
                     sab = blend(sa, sb);
                     wab = blend(wa, wb);
                     col = 12 * x + 3 * p;
                     emit(row, col, sa);
                     emit(row, col + 1, sab);
                     emit(row, col + 2, sb);
                     emit(row + 1, col, blend(sa, wa));
                     emit(row + 1, col + 1, blend(sab, wab));
                     emit(row + 1, col + 2, blend(sb, wb));
                     emit(row + 2, col, wa);
                     emit(row + 2, col + 1, wab);
                     emit(row + 2, col + 2, wb);
                  end
               end
            end
            MODE_SCALE74: begin
               row = int'(ROW_TOP_DOUBLED) + 2 * y;
               for (int g = 0; g < 2; g++) begin
                  for (int i = 0; i < 4; i++) c[i] = shade(w, 4 * g + i);
                  seq[0] = c[0];
                  seq[1] = blend(c[0], c[1]);
                  seq[2] = c[1];
                  seq[3] = blend(c[1], c[2]);
                  seq[4] = c[2];
                  seq[5] = blend(c[2], c[3]);
                  seq[6] = c[3];
                  for (int i = 0; i < 7; i++) begin
                     col = 14 * x + 7 * g + i;
                     emit(row, col, seq[i]);
                     emit(row + 1, col, seq[i]);
                  end
               end
            end
            MODE_DOUBLE: begin
               row = int'(ROW_TOP_DOUBLED) + 2 * y;
               for (int b = 0; b < 8; b++) begin
                  col = 16 * x + 2 * b;
                  emit(row, col, shade(w, b));
                  emit(row, col + 1, shade(w, b));
                  emit(row + 1, col, shade(w, b));
                  emit(row + 1, col + 1, shade(w, b));
               end
            end
            default: ;
         endcase
         // even lines are kept whatever the mode
         if (!line[0]) line_store[column] = w;
         if (holding) begin
            held.last = 1'b1;
            pending_pixels.push_back(held);
            holding = 1'b0;
         end
         if (column == COL_W'(WORDS_PER_LINE - 1)) line = line + 1'b1;
         column = column + 1'b1;
      endfunction

      function int pending();
         return pending_pixels.size();
      endfunction

      function void fault(string what);
         errors++;
         if (errors <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_pixel(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                color_type color, logic last);
         pixel_type e;
         if (pending_pixels.size() == 0) begin
            fault($sformatf("unexpected pixel row %0d col %0d colour %06h", row, col, color));
            return;
         end
         e = pending_pixels.pop_front();
         if (row != e.row)
            fault($sformatf("row: expected %0d, got %0d", e.row, row));
         if (col != e.col)
            fault($sformatf("column at row %0d: expected %0d, got %0d", e.row, e.col, col));
         if (color != e.color)
            fault($sformatf("colour at row %0d col %0d: expected %06h, got %06h",
                            e.row, e.col, e.color, color));
         if (last != e.last)
            fault($sformatf("last flag at row %0d col %0d: expected %0b, got %0b",
                            e.row, e.col, e.last, last));
      endfunction

      function void close();
         if (pending_pixels.size() != 0)
            fault($sformatf("%0d pixels never arrived", pending_pixels.size()));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_W-1:0]      req_tdata = '0;        // video_word
   logic                   req_tuser = 1'b0;      // frame_start
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;             // out_row, out_col, pixel_color, zero pad
   logic                   rsp_tlast;
   logic                   csr_wr_en = 1'b0;
   csr_index_type          csr_index = CSR_MODE;
   logic [COLOR_W-1:0]     csr_wdata = '0;

   raster_scoreboard sb;
   int sender_idle_pct   = 7;
   int receiver_stall_pct = 86;
   int rsp_hold           = 0;
   int quiet_cycles       = 0;

   planar_video_scaler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // result side: check each transfer, stall at random or for a requested stretch
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pixel(rsp_tdata[POS_W-1:0], rsp_tdata[2*POS_W-1:POS_W],
                        rsp_tdata[2*POS_W +: COLOR_W], rsp_tlast);
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (int'($urandom_range(0, 99)) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] w, input logic frame_start);
      while (int'($urandom_range(0, 99)) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      sb.take_word(w, frame_start);
   endtask

   // wait for every pixel, then give words without pixels time to leave the front
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic reconfigure(input mode_type m, input palette_type pal);
      logic [COLOR_W-1:0] mode_word;
      settle();
      // upper bits are junk: only the low bits of the mode register are kept
      mode_word = {21'($urandom), m};
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= mode_word;
      @(posedge clock);
      sb.write_reg(CSR_MODE, mode_word);
      for (int i = 0; i < 4; i++) begin
         csr_index <= csr_index_type'(CSR_PAL_BLACK + i);
         csr_wdata <= pal[i];
         @(posedge clock);
         sb.write_reg(csr_index_type'(CSR_PAL_BLACK + i), pal[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic palette_type random_palette();
      palette_type pal;
      for (int i = 0; i < 4; i++) begin
         case ($urandom_range(0, 3))
            0:       pal[i] = '0;
            1:       pal[i] = '1;
            default: pal[i] = color_type'($urandom);
         endcase
      end
      return pal;
   endfunction

   task automatic random_stretch(input int budget);
      int          done;
      int          words;
      mode_type    m;
      palette_type pal;
      logic        fs;
      done = 0;
      while (done < budget) begin
         if ($urandom_range(0, 99) < 12)
            m = mode_type'($urandom_range(MODE_DOUBLE + 1, MODE_SILENT));
         else
            m = mode_type'($urandom_range(MODE_NATIVE, MODE_DOUBLE));
         // scaled mode only yields pixels on odd lines
         if (m == MODE_SCALE32 && !sb.line[0])
            m = MODE_SCALE74;
         pal = $urandom_range(0, 1) ? random_palette() : sb.palette;
         reconfigure(m, pal);
         words = int'($urandom_range(2, 12));
         for (int k = 0; k < words; k++) begin
            if (m == MODE_SCALE32)
               fs = 1'b0;
            else if (k == 0)
               fs = ($urandom_range(0, 7) == 0);
            else
               fs = ($urandom_range(0, 63) == 0);
            send_word(WORD_W'($urandom), fs);
         end
         done += words;
      end
   endtask

   // run quietly until lead words remain in the current line, then cross into the next in mode m
   task automatic cross_line_wrap(input mode_type m, input int lead);
      reconfigure(MODE_SILENT, sb.palette);
      while (sb.column != COL_W'(WORDS_PER_LINE - lead))
         send_word(WORD_W'($urandom), 1'b0);
      reconfigure(m, random_palette());
      repeat (lead + 3) send_word(WORD_W'($urandom), 1'b0);
   endtask

   initial begin : stimulus
      palette_type pal;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pass a whole even line so the scaled lines below read written entries
      cross_line_wrap(MODE_DOUBLE, 6);

      pal[0] = 24'h000000;
      pal[1] = 24'h13579B;
      pal[2] = 24'hFFFFFF;
      pal[3] = 24'hFEFF01;
      reconfigure(MODE_SCALE32, pal);
      send_word(16'h0000, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h00FF, 1'b0);
      send_word(16'hFF00, 1'b0);
      send_word(16'h5AA5, 1'b0);
      reconfigure(MODE_NATIVE, pal);
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'h8001, 1'b0);
      send_word(16'h0180, 1'b0);
      reconfigure(MODE_SHIFTED, pal);
      send_word(16'h00FF, 1'b0);
      send_word(16'hFF00, 1'b0);
      reconfigure(MODE_SCALE74, pal);
      send_word(16'hE41B, 1'b0);
      send_word(16'h1BE4, 1'b0);
      reconfigure(MODE_DOUBLE, pal);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h3C3C, 1'b0);
      reconfigure(mode_type'(MODE_DOUBLE + 1), pal);
      send_word(16'hA5A5, 1'b0);
      send_word(16'h5A5A, 1'b1);
      reconfigure(MODE_SILENT, pal);
      send_word(16'hC3C3, 1'b0);
      // even line in scaled mode: stored, nothing shown
      reconfigure(MODE_SCALE32, pal);
      send_word(16'h7E81, 1'b1);

      // block the result side long enough for the queue to fill and stall the input
      reconfigure(MODE_DOUBLE, random_palette());
      rsp_hold = 600;
      repeat (10) send_word(WORD_W'($urandom), 1'b0);
      random_stretch(24);

      settle();
      sender_idle_pct    = 86;
      receiver_stall_pct = 7;
      random_stretch(24);

      settle();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      random_stretch(24);

      settle();
      repeat (40) @(posedge clock);
      sb.close();
      if (sb.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
